/* rtl/core/pll_latch_word_builder_macros.svh */
// assertion macros shared by the latch word builder rtl
// no dependencies; taken in by `include in the files that assert
`ifndef PLL_LATCH_WORD_BUILDER_MACROS_SVH
`define PLL_LATCH_WORD_BUILDER_MACROS_SVH

// condition holds at every edge out of reset
`define PLWB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PLWB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PLWB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/plwb_pkg.sv */
// types and constants of the latch word builder
// no dependencies; used by every module of the block
package plwb_pkg;

   // field widths
   localparam int FREQ_W    = 32;
   localparam int WORD_W    = 24;
   localparam int DIV_W     = 20;
   localparam int DVD_W     = 34;
   localparam int STEPS_W   = 24;
   localparam int R_W       = 14;
   localparam int B_W       = 13;
   localparam int A_W       = 5;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CNT_W     = 5;

   // tuning arithmetic: target is the offset frequency over 500, taken as
   // a quarter of it over 125 by a reciprocal multiply
   localparam int SCALE_W     = 31;
   localparam int RECIP_W     = 29;
   localparam int PROD_W      = SCALE_W + RECIP_W;
   localparam int RECIP_SHIFT = 35;
   localparam logic [FREQ_W:0]    TUNE_OFFSET = 33'd739000000;
   localparam logic [RECIP_W-1:0] RECIP_125   = 29'd274877907;
   localparam logic [CNT_W-1:0]   DIV2_PAIRS  = 5'd12;

   // counter limits
   localparam logic [R_W-1:0] R_MAX = 14'd16383;
   localparam logic [R_W-1:0] R_MIN = 14'd1;
   localparam logic [B_W-1:0] B_MAX = 13'd8191;
   localparam logic [B_W-1:0] B_MIN = 13'd3;
   localparam logic [A_W-1:0] A_MAX = 5'd31;
   localparam logic [A_W-1:0] A_MIN = 5'd2;

   // control bits at the foot of each word
   localparam logic [1:0] BITS_R    = 2'b01;
   localparam logic [1:0] BITS_CTRL = 2'b00;
   localparam logic [1:0] BITS_N    = 2'b10;

   // register reset values
   localparam logic [19:0] STEP_RESET = 20'd10;
   localparam logic [15:0] REFD_RESET = 16'd1000;
   localparam logic [1:0]  PSEL_RESET = 2'd2;
   localparam logic [5:0]  ROPT_RESET = 6'd48;
   localparam logic [21:0] COPT_RESET = 22'd1032488;
   localparam logic [2:0]  NOPT_RESET = 3'd0;

   typedef enum logic [2:0] {
      REG_STEP = 3'd0,
      REG_REFD = 3'd1,
      REG_PSEL = 3'd2,
      REG_ROPT = 3'd3,
      REG_COPT = 3'd4,
      REG_NOPT = 3'd5
   } plwb_reg_type;

   typedef enum logic [1:0] {
      KIND_R    = 2'd0,
      KIND_CTRL = 2'd1,
      KIND_N    = 2'd2
   } plwb_kind_type;

   typedef struct packed {
      logic [19:0] step_size;
      logic [15:0] ref_divide;
      logic [1:0]  prescaler_sel;
      logic [5:0]  r_latch_options;
      logic [21:0] control_latch_options;
      logic [2:0]  n_latch_options;
   } plwb_cfg_type;

   typedef struct packed {
      logic              valid;
      logic [FREQ_W-1:0] freq;
   } plwb_item_type;

endpackage

/* rtl/core/plwb_csr.sv */
// configuration register bank with apb-style write and read
// depends on plwb_pkg
module plwb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [plwb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [plwb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [plwb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output plwb_pkg::plwb_cfg_type              cfg
);

   plwb_pkg::plwb_cfg_type cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            plwb_pkg::REG_STEP: cfg_in.step_size             = csr_pwdata[19:0];
            plwb_pkg::REG_REFD: cfg_in.ref_divide            = csr_pwdata[15:0];
            plwb_pkg::REG_PSEL: cfg_in.prescaler_sel         = csr_pwdata[1:0];
            plwb_pkg::REG_ROPT: cfg_in.r_latch_options       = csr_pwdata[5:0];
            plwb_pkg::REG_COPT: cfg_in.control_latch_options = csr_pwdata[21:0];
            plwb_pkg::REG_NOPT: cfg_in.n_latch_options       = csr_pwdata[2:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // readback mux
   always_comb begin
      unique case (reg_idx)
         plwb_pkg::REG_STEP: csr_prdata = 32'(cfg_ff.step_size);
         plwb_pkg::REG_REFD: csr_prdata = 32'(cfg_ff.ref_divide);
         plwb_pkg::REG_PSEL: csr_prdata = 32'(cfg_ff.prescaler_sel);
         plwb_pkg::REG_ROPT: csr_prdata = 32'(cfg_ff.r_latch_options);
         plwb_pkg::REG_COPT: csr_prdata = 32'(cfg_ff.control_latch_options);
         plwb_pkg::REG_NOPT: csr_prdata = 32'(cfg_ff.n_latch_options);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size             <= plwb_pkg::STEP_RESET;
         cfg_ff.ref_divide            <= plwb_pkg::REFD_RESET;
         cfg_ff.prescaler_sel         <= plwb_pkg::PSEL_RESET;
         cfg_ff.r_latch_options       <= plwb_pkg::ROPT_RESET;
         cfg_ff.control_latch_options <= plwb_pkg::COPT_RESET;
         cfg_ff.n_latch_options       <= plwb_pkg::NOPT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/plwb_front.sv */
// front end: takes requests and drops a repeat of the last frequency
// depends on plwb_pkg
module plwb_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [plwb_pkg::FREQ_W-1:0]     req_tdata,
   input  logic                            queue_full,
   output plwb_pkg::plwb_item_type         push
);

   logic [plwb_pkg::FREQ_W-1:0] last_freq_ff, last_freq_in;
   logic                        req_xfer;
   logic                        is_new;

   assign req_tready = !queue_full;
   assign req_xfer   = req_tvalid && req_tready;
   assign is_new     = req_tdata != last_freq_ff;

   // only a changed frequency goes on to the queue
   always_comb begin
      push.valid   = req_xfer && is_new;
      push.freq    = req_tdata;
      last_freq_in = req_xfer ? req_tdata : last_freq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_freq_ff <= '0;
      end else begin
         last_freq_ff <= last_freq_in;
      end
   end

endmodule

/* rtl/core/plwb_queue.sv */
// short queue of frequencies between front end and word engine
// depends on plwb_pkg and the assertion macro header
`include "pll_latch_word_builder_macros.svh"
module plwb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  plwb_pkg::plwb_item_type  push,
   output logic                     full,
   input  logic                     pop_ready,
   output plwb_pkg::plwb_item_type  pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [plwb_pkg::FREQ_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop.valid = count_ff != '0;
   assign pop.freq  = entry_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop_ready && pop.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.freq;
      end
   end

   `PLWB_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue overfilled")
   `PLWB_ASSERT_IMPLY(a_no_push_full, clock, reset, push.valid, !full, "push into full queue")

endmodule

/* rtl/core/plwb_back.sv */
// word engine: reciprocal multiply for the target, radix-4 divider for the
// step count, clamping and word output; depends on plwb_pkg and the macro header
`include "pll_latch_word_builder_macros.svh"
module plwb_back (
   input  logic                           clock,
   input  logic                           reset,
   input  plwb_pkg::plwb_item_type        pop,
   output logic                           pop_ready,
   input  plwb_pkg::plwb_cfg_type         cfg,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [plwb_pkg::WORD_W-1:0]    rsp_tdata,
   output logic                           rsp_tlast,
   output logic [1:0]                     rsp_tuser
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCALE = 4'b0010,
      ST_DIV2  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   localparam int DVD_W   = plwb_pkg::DVD_W;
   localparam int DIV_W   = plwb_pkg::DIV_W;
   localparam int STEPS_W = plwb_pkg::STEPS_W;

   state_type                      state_ff, state_in;
   logic [plwb_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DVD_W-1:0]               dvd_ff, dvd_in;
   logic [DIV_W-1:0]               rem_ff, rem_in;
   logic [DIV_W-1:0]               div_ff, div_in;
   plwb_pkg::plwb_kind_type        kind_ff, kind_in;
   logic                           out_valid_ff, out_valid_in;
   logic [plwb_pkg::WORD_W-1:0]    out_word_ff, out_word_in;
   plwb_pkg::plwb_kind_type        out_kind_ff, out_kind_in;
   logic                           out_last_ff, out_last_in;

   logic [DVD_W-1:0]               step_dvd;
   logic [DIV_W-1:0]               step_rem;
   logic [DIV_W:0]                 trial;
   logic [plwb_pkg::FREQ_W:0]      tune_sum;
   logic [plwb_pkg::PROD_W-1:0]    scale_prod;
   logic [STEPS_W-1:0]             target;
   logic [STEPS_W-1:0]             steps;
   logic [STEPS_W-1:0]             b_raw;
   logic [6:0]                     a_mask;
   logic [5:0]                     a_raw;
   logic [plwb_pkg::B_W-1:0]       b_val;
   logic [plwb_pkg::A_W-1:0]       a_val;
   logic [plwb_pkg::R_W-1:0]       r_val;
   logic [plwb_pkg::WORD_W-1:0]    word;
   logic                           out_free;

   assign pop_ready  = state_ff == ST_IDLE;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_kind_ff;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign tune_sum   = {1'b0, pop.freq} + plwb_pkg::TUNE_OFFSET;

   // target: quarter of the offset frequency times the reciprocal of 125,
   // a 31 by 29 bit product
   assign scale_prod = {{plwb_pkg::RECIP_W{1'b0}}, dvd_ff[plwb_pkg::SCALE_W-1:0]}
                     * {{plwb_pkg::SCALE_W{1'b0}}, plwb_pkg::RECIP_125};
   assign target     = scale_prod[plwb_pkg::RECIP_SHIFT +: STEPS_W];

   // two restoring divide steps per cycle
   always_comb begin
      step_dvd = dvd_ff;
      step_rem = rem_ff;
      trial    = '0;
      for (int i = 0; i < 2; i++) begin
         trial = {step_rem, step_dvd[DVD_W-1]};
         if (trial >= {1'b0, div_ff}) begin
            step_rem = DIV_W'(trial - {1'b0, div_ff});
            step_dvd = {step_dvd[DVD_W-2:0], 1'b1};
         end else begin
            step_rem = trial[DIV_W-1:0];
            step_dvd = {step_dvd[DVD_W-2:0], 1'b0};
         end
      end
   end

   // counter clamping from the step count
   always_comb begin
      steps  = dvd_ff[STEPS_W-1:0];
      b_raw  = (steps >> 3) >> cfg.prescaler_sel;
      a_mask = (7'd8 << cfg.prescaler_sel) - 7'd1;
      a_raw  = steps[5:0] & a_mask[5:0];
      if (b_raw < STEPS_W'(plwb_pkg::B_MIN)) begin
         b_val = plwb_pkg::B_MIN;
      end else if (b_raw > STEPS_W'(plwb_pkg::B_MAX)) begin
         b_val = plwb_pkg::B_MAX;
      end else begin
         b_val = b_raw[plwb_pkg::B_W-1:0];
      end
      if (a_raw < 6'(plwb_pkg::A_MIN)) begin
         a_val = plwb_pkg::A_MIN;
      end else if (a_raw > 6'(plwb_pkg::A_MAX)) begin
         a_val = plwb_pkg::A_MAX;
      end else begin
         a_val = a_raw[plwb_pkg::A_W-1:0];
      end
      if (cfg.ref_divide < 16'(plwb_pkg::R_MIN)) begin
         r_val = plwb_pkg::R_MIN;
      end else if (cfg.ref_divide > 16'(plwb_pkg::R_MAX)) begin
         r_val = plwb_pkg::R_MAX;
      end else begin
         r_val = cfg.ref_divide[plwb_pkg::R_W-1:0];
      end
   end

   // latch word assembly
   always_comb begin
      unique case (kind_ff)
         plwb_pkg::KIND_R: begin
            word = {2'b00, cfg.r_latch_options, r_val, plwb_pkg::BITS_R};
         end
         plwb_pkg::KIND_CTRL: begin
            word = {cfg.prescaler_sel, cfg.control_latch_options[21:2],
                    plwb_pkg::BITS_CTRL};
         end
         plwb_pkg::KIND_N: begin
            word = {cfg.n_latch_options, b_val, 1'b0, a_val, plwb_pkg::BITS_N};
         end
         default: word = '0;
      endcase
   end

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      kind_in      = kind_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_word_in  = out_word_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop.valid) begin
               dvd_in   = DVD_W'(tune_sum[plwb_pkg::FREQ_W:2]);
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            dvd_in   = {target, {(DVD_W - STEPS_W){1'b0}}};
            rem_in   = '0;
            div_in   = (cfg.step_size == '0) ? DIV_W'(1) : cfg.step_size;
            cnt_in   = plwb_pkg::DIV2_PAIRS;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            dvd_in = step_dvd;
            rem_in = step_rem;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == plwb_pkg::CNT_W'(1)) begin
               kind_in  = plwb_pkg::KIND_R;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_word_in  = word;
               out_kind_in  = kind_ff;
               out_last_in  = kind_ff == plwb_pkg::KIND_N;
               unique case (kind_ff)
                  plwb_pkg::KIND_R:    kind_in = plwb_pkg::KIND_CTRL;
                  plwb_pkg::KIND_CTRL: kind_in = plwb_pkg::KIND_N;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         kind_ff      <= plwb_pkg::KIND_R;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      out_word_ff <= out_word_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   `PLWB_ASSERT_IMPLY(a_rem_below_div, clock, reset, state_ff == ST_DIV2,
                      rem_ff < div_ff, "divider remainder not below divisor")
   `PLWB_ASSERT_NEXT(a_pop_starts, clock, reset, pop_ready && pop.valid,
                     state_ff == ST_SCALE, "popped item did not start the engine")

endmodule

/* rtl/core/pll_latch_word_builder.sv */
// top level of the latch word builder for a dual-modulus integer-n synthesiser
// depends on plwb_pkg, plwb_csr, plwb_front, plwb_queue and plwb_back
//
// channel  | direction | transfer content
// req_     | in        | tdata[31:0] requested frequency
// rsp_     | out       | tdata[23:0] latch word, tuser[1:0] word kind, tlast on n word
// csr_     | in/out    | apb-style access to six registers at byte address 4*i
//
// a request is taken while the queue has room; a repeat of the last frequency ends there
// in the word engine a new frequency passes a load state, the reciprocal
// multiply for the target and the divider for the step count, then emits
// one latch word per cycle while the output register is free
// the queue takes further requests while the engine works or the output stalls
// reset is synchronous and active high; it restores register defaults and
// clears the last frequency to zero
module pll_latch_word_builder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [plwb_pkg::FREQ_W-1:0]         req_tdata,   // [31:0] req_freq
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [plwb_pkg::WORD_W-1:0]         rsp_tdata,   // [23:0] latch_word
   output logic                                rsp_tlast,
   output logic [1:0]                          rsp_tuser,   // [1:0] latch_kind
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [plwb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [plwb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [plwb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   plwb_pkg::plwb_cfg_type  cfg;
   plwb_pkg::plwb_item_type push;
   plwb_pkg::plwb_item_type pop;
   logic                    queue_full;
   logic                    pop_ready;

   // configuration registers
   plwb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // request intake and repeat filter
   plwb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push)
   );

   // decoupling queue
   plwb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop_ready (pop_ready),
      .pop       (pop)
   );

   // divider and word output
   plwb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .pop_ready  (pop_ready),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* tb/pll_latch_word_builder_tb.sv */
// testbench for pll_latch_word_builder: drives frequency requests and register writes,
// predicts the r, control and n latch words and checks every result transfer
// depends on plwb_pkg and the pll_latch_word_builder rtl
`timescale 1ns / 100ps

module pll_latch_word_builder_tb;

   // register index with no register behind it
   localparam logic [2:0] REG_NONE = 3'd6;
   localparam logic [63:0] TUNE_OFS = 64'd739000000;

   typedef struct {
      logic [plwb_pkg::WORD_W-1:0] word;
      plwb_pkg::plwb_kind_type     kind;
      logic                        last;
   } latch_word_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [plwb_pkg::FREQ_W-1:0]         req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [plwb_pkg::WORD_W-1:0]         rsp_tdata;
   logic                                rsp_tlast;
   logic [1:0]                          rsp_tuser;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [plwb_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [plwb_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [plwb_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   // stimulus and prediction state
   logic [plwb_pkg::FREQ_W-1:0] freq_q[$];
   latch_word_type              latch_words_due[$];
   plwb_pkg::plwb_cfg_type      cfg;
   logic [plwb_pkg::FREQ_W-1:0] last_freq_taken;
   logic [plwb_pkg::FREQ_W-1:0] prev_freq;
   bit                          req_taken = 1'b0;
   bit                          calm = 1'b0;
   int                          send_gap = 0;
   int                          recv_stall = 0;
   int                          fail_count = 0;

   pll_latch_word_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [31:0] req_freq
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [23:0] latch_word
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),   // [1:0] latch_kind
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // works out the three latch words for a new frequency, none for a repeat
   function automatic void build_latch_words(input logic [plwb_pkg::FREQ_W-1:0] freq);
      logic [63:0]    target;
      logic [63:0]    divisor;
      logic [63:0]    steps;
      logic [63:0]    modulus;
      logic [63:0]    b_cnt;
      logic [63:0]    a_cnt;
      logic [63:0]    r_cnt;
      latch_word_type lw;
      if (freq == last_freq_taken) begin
         return;
      end
      last_freq_taken = freq;
      target  = (64'd2 * ({32'd0, freq} + TUNE_OFS)) / 64'd1000;
      divisor = (cfg.step_size == '0) ? 64'd1 : {44'd0, cfg.step_size};
      steps   = target / divisor;
      modulus = 64'd8 << cfg.prescaler_sel;
      b_cnt   = steps / modulus;
      a_cnt   = steps % modulus;
      // saturate the counters into their fields
      if (b_cnt < 64'(plwb_pkg::B_MIN)) b_cnt = 64'(plwb_pkg::B_MIN);
      if (b_cnt > 64'(plwb_pkg::B_MAX)) b_cnt = 64'(plwb_pkg::B_MAX);
      if (a_cnt < 64'(plwb_pkg::A_MIN)) a_cnt = 64'(plwb_pkg::A_MIN);
      if (a_cnt > 64'(plwb_pkg::A_MAX)) a_cnt = 64'(plwb_pkg::A_MAX);
      r_cnt = {48'd0, cfg.ref_divide};
      if (r_cnt < 64'(plwb_pkg::R_MIN)) r_cnt = 64'(plwb_pkg::R_MIN);
      if (r_cnt > 64'(plwb_pkg::R_MAX)) r_cnt = 64'(plwb_pkg::R_MAX);
      lw.word = {2'b00, cfg.r_latch_options, r_cnt[plwb_pkg::R_W-1:0], plwb_pkg::BITS_R};
      lw.kind = plwb_pkg::KIND_R;
      lw.last = 1'b0;
      latch_words_due.push_back(lw);
      lw.word = {cfg.prescaler_sel, cfg.control_latch_options[21:2], plwb_pkg::BITS_CTRL};
      lw.kind = plwb_pkg::KIND_CTRL;
      latch_words_due.push_back(lw);
      lw.word = {cfg.n_latch_options, b_cnt[plwb_pkg::B_W-1:0], 1'b0,
                 a_cnt[plwb_pkg::A_W-1:0], plwb_pkg::BITS_N};
      lw.kind = plwb_pkg::KIND_N;
      lw.last = 1'b1;
      latch_words_due.push_back(lw);
   endfunction

   // register value biased towards the ends of its range
   function automatic logic [31:0] pick_value(input int unsigned lo, input int unsigned hi);
      int unsigned sel;
      sel = $urandom_range(0, 5);
      if (sel == 0) return lo;
      if (sel == 1) return hi;
      return $urandom_range(lo, hi);
   endfunction

   // apb write: setup cycle then access cycle
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         plwb_pkg::REG_STEP: cfg.step_size             = value[19:0];
         plwb_pkg::REG_REFD: cfg.ref_divide            = value[15:0];
         plwb_pkg::REG_PSEL: cfg.prescaler_sel         = value[1:0];
         plwb_pkg::REG_ROPT: cfg.r_latch_options       = value[5:0];
         plwb_pkg::REG_COPT: cfg.control_latch_options = value[21:0];
         plwb_pkg::REG_NOPT: cfg.n_latch_options       = value[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // block idle: nothing queued, nothing due, then the engine's latency
   task automatic wait_drained();
      while (freq_q.size() != 0 || req_tvalid || latch_words_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // request driver with random gaps
   always @(negedge clock) begin
      if (!reset && !(req_tvalid && !req_taken)) begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (freq_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 10) - 1;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= freq_q[0];
         end
      end
   end

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         recv_stall = $urandom_range(1, 10) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin : result_monitor
      latch_word_type lw;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            build_latch_words(req_tdata);
            freq_q.delete(0);
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (latch_words_due.size() == 0) begin
               $error("latch_word transfer with none due: word %06h kind %0d last %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               lw = latch_words_due.pop_front();
               if (rsp_tdata !== lw.word) begin
                  $error("latch_word expected %06h got %06h", lw.word, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== lw.kind) begin
                  $error("latch_kind expected %0d got %0d", lw.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== lw.last) begin
                  $error("last_word expected %0b got %0b", lw.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [plwb_pkg::FREQ_W-1:0] f;
      int unsigned                 k;
      cfg.step_size             = plwb_pkg::STEP_RESET;
      cfg.ref_divide            = plwb_pkg::REFD_RESET;
      cfg.prescaler_sel         = plwb_pkg::PSEL_RESET;
      cfg.r_latch_options       = plwb_pkg::ROPT_RESET;
      cfg.control_latch_options = plwb_pkg::COPT_RESET;
      cfg.n_latch_options       = plwb_pkg::NOPT_RESET;
      last_freq_taken = '0;
      prev_freq       = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: zero repeats the cleared last frequency, then repeats and extremes
      freq_q.push_back(32'd0);
      freq_q.push_back(32'd1);
      freq_q.push_back(32'd1);
      freq_q.push_back(32'hFFFF_FFFF);
      freq_q.push_back(32'h8000_0000);
      freq_q.push_back(32'd0);
      wait_drained();

      // low extremes: zero step size, zero reference, smallest prescale, options all ones
      csr_write(plwb_pkg::REG_STEP, 32'd0);
      csr_write(plwb_pkg::REG_REFD, 32'd0);
      csr_write(plwb_pkg::REG_PSEL, 32'd0);
      csr_write(plwb_pkg::REG_ROPT, 32'd63);
      csr_write(plwb_pkg::REG_COPT, 32'd4194303);
      csr_write(plwb_pkg::REG_NOPT, 32'd7);
      freq_q.push_back(32'd12345);
      freq_q.push_back(32'hFFFF_FFFF);
      freq_q.push_back(32'd0);
      freq_q.push_back(32'h5555_5555);
      wait_drained();

      // high extremes, plus writes to addresses with no register
      csr_write(plwb_pkg::REG_STEP, 32'd1048575);
      csr_write(plwb_pkg::REG_REFD, 32'd65535);
      csr_write(plwb_pkg::REG_PSEL, 32'd3);
      csr_write(plwb_pkg::REG_ROPT, 32'd0);
      csr_write(plwb_pkg::REG_COPT, 32'd0);
      csr_write(plwb_pkg::REG_NOPT, 32'd0);
      csr_write(REG_NONE, 32'hFFFF_FFFF);
      csr_write(REG_NONE + 3'd1, 32'hFFFF_FFFF);
      freq_q.push_back(32'd0);
      freq_q.push_back(32'hFFFF_FFFF);
      freq_q.push_back(32'hAAAA_AAAA);
      wait_drained();

      // unit step with the largest prescale: a counter clamps low and high
      csr_write(plwb_pkg::REG_STEP, 32'd1);
      freq_q.push_back(32'd8000);
      freq_q.push_back(32'd0);
      wait_drained();
      prev_freq = 32'd0;

      // random settings, each phase drained before the next
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 4) calm = 1'b1;
         csr_write(plwb_pkg::REG_STEP, ($urandom_range(0, 1) == 0) ? $urandom_range(1, 200)
                                                                   : pick_value(0, 1048575));
         csr_write(plwb_pkg::REG_REFD, pick_value(0, 65535));
         csr_write(plwb_pkg::REG_PSEL, pick_value(0, 3));
         csr_write(plwb_pkg::REG_ROPT, pick_value(0, 63));
         csr_write(plwb_pkg::REG_COPT, pick_value(0, 4194303));
         csr_write(plwb_pkg::REG_NOPT, pick_value(0, 7));
         for (int n = 0; n < 20; n++) begin
            k = $urandom_range(0, 9);
            if (k < 2) f = prev_freq;
            else if (k == 2) f = $urandom_range(0, 255);
            else if (k == 3) f = 32'hFFFF_FF00 | $urandom_range(0, 255);
            else f = $urandom;
            freq_q.push_back(f);
            prev_freq = f;
         end
         wait_drained();
      end

      if (fail_count == 0 && latch_words_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* pll_latch_word_builder.f */
+incdir+rtl/core
rtl/core/plwb_pkg.sv
rtl/core/plwb_csr.sv
rtl/core/plwb_front.sv
rtl/core/plwb_queue.sv
rtl/core/plwb_back.sv
rtl/core/pll_latch_word_builder.sv
tb/pll_latch_word_builder_tb.sv
